FILE: rtl/bmhq_pkg.sv
// Shared types, constants and helpers for the binary max-heap priority queue.
// No dependencies; imported by every module of the block but bmhq_ram.
`default_nettype none

package bmhq_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [COUNT_W-1:0]      pos_t;
  typedef logic [ADDR_W-1:0]       addr_t;

  typedef struct packed {
    logic cmd;
    key_t value;
  } in_t;

  typedef struct packed {
    key_t       top_value;
    pos_t       entry_count;
    logic       is_empty;
    logic       dropped;
  } out_t;

  // Engine to top level: end-of-operation status.
  typedef struct packed {
    logic done;
    logic dropped;
    pos_t count;
    key_t root;
  } sift_status_t;

  // Heap positions are 1-based; the store is 0-based.
  function automatic addr_t pos_to_addr(input pos_t p);
    pos_t d;
    d = p - COUNT_W'(1);
    return d[ADDR_W-1:0];
  endfunction

  function automatic logic key_gt(input key_t a, input key_t b);
    return a > b;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/bmhq_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module bmhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/bmhq_sift.sv
// Sift sequencer: one shared signed comparator stepped by a one-hot FSM,
// walking the heap in bmhq_ram for push (sift up) and pop (sift down). Uses bmhq_pkg.
`default_nettype none

module bmhq_sift (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  accept,
  input  wire bmhq_pkg::in_t         item,
  output logic                       busy,
  output bmhq_pkg::sift_status_t     status,
  output logic                       mem_we,
  output bmhq_pkg::addr_t            mem_waddr,
  output bmhq_pkg::key_t             mem_wdata,
  output bmhq_pkg::addr_t            mem_raddr,
  input  wire bmhq_pkg::key_t        mem_rdata
);
  import bmhq_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_PUSH_RD  = 9'b000000010,
    ST_PUSH_CMP = 9'b000000100,
    ST_POP_LAST = 9'b000001000,
    ST_DN_RDL   = 9'b000010000,
    ST_DN_RDR   = 9'b000100000,
    ST_DN_CMP   = 9'b001000000,
    ST_DN_MOVE  = 9'b010000000,
    ST_DONE     = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  pos_t   count_r, count_nxt;
  pos_t   pos_r, pos_nxt;
  pos_t   pick_r, pick_nxt;
  key_t   key_r, key_nxt;
  key_t   lval_r, lval_nxt;
  key_t   pval_r, pval_nxt;
  key_t   root_r, root_nxt;
  logic   dropped_r, dropped_nxt;

  logic               [COUNT_W:0] left_pos;
  logic               [COUNT_W:0] right_pos;
  logic                           left_out;
  logic                           right_out;
  pos_t                           parent_pos;
  pos_t                           wr_pos;
  key_t                           cmp_a;
  key_t                           cmp_b;
  logic                           cmp_gt;

  assign left_pos   = {pos_r, 1'b0};
  assign right_pos  = left_pos + (COUNT_W + 1)'(1);
  assign left_out   = left_pos > {1'b0, count_r};
  assign right_out  = right_pos > {1'b0, count_r};
  assign parent_pos = pos_r >> 1;

  // Shared comparator operand select.
  always_comb begin
    unique case (state_r)
      ST_DN_CMP:  begin cmp_a = lval_r; cmp_b = mem_rdata; end
      ST_DN_MOVE: begin cmp_a = pval_r; cmp_b = key_r;     end
      default:    begin cmp_a = key_r;  cmp_b = mem_rdata; end
    endcase
  end

  assign cmp_gt = key_gt(cmp_a, cmp_b);

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    pos_nxt     = pos_r;
    pick_nxt    = pick_r;
    key_nxt     = key_r;
    lval_nxt    = lval_r;
    pval_nxt    = pval_r;
    dropped_nxt = dropped_r;
    mem_we      = 1'b0;
    wr_pos      = pos_r;
    mem_wdata   = key_r;
    mem_raddr   = pos_to_addr(parent_pos);

    unique case (state_r)
      ST_IDLE: begin
        mem_raddr = pos_to_addr(count_r);
        if (accept) begin
          dropped_nxt = 1'b0;
          if (item.cmd == CMD_PUSH) begin
            if (count_r == COUNT_W'(CAPACITY)) begin
              dropped_nxt = 1'b1;
              state_nxt   = ST_DONE;
            end else begin
              count_nxt = count_r + COUNT_W'(1);
              pos_nxt   = count_r + COUNT_W'(1);
              key_nxt   = item.value;
              state_nxt = ST_PUSH_RD;
            end
          end else begin
            if (count_r == '0) begin
              dropped_nxt = 1'b1;
              state_nxt   = ST_DONE;
            end else begin
              state_nxt = ST_POP_LAST;   // last entry read issued this cycle
            end
          end
        end
      end
      ST_PUSH_RD: begin
        if (pos_r == COUNT_W'(1)) begin
          mem_we    = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_PUSH_CMP;
        end
      end
      ST_PUSH_CMP: begin
        mem_we = 1'b1;
        if (cmp_gt) begin
          mem_wdata = mem_rdata;         // parent moves down
          pos_nxt   = parent_pos;
          state_nxt = ST_PUSH_RD;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_POP_LAST: begin
        key_nxt   = mem_rdata;
        count_nxt = count_r - COUNT_W'(1);
        pos_nxt   = COUNT_W'(1);
        state_nxt = (count_r == COUNT_W'(1)) ? ST_DONE : ST_DN_RDL;
      end
      ST_DN_RDL: begin
        mem_raddr = pos_to_addr(left_pos[COUNT_W-1:0]);
        if (left_out) begin
          mem_we    = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_DN_RDR;
        end
      end
      ST_DN_RDR: begin
        mem_raddr = pos_to_addr(right_pos[COUNT_W-1:0]);
        lval_nxt  = mem_rdata;
        if (right_out) begin
          pick_nxt  = left_pos[COUNT_W-1:0];
          pval_nxt  = mem_rdata;
          state_nxt = ST_DN_MOVE;
        end else begin
          state_nxt = ST_DN_CMP;
        end
      end
      ST_DN_CMP: begin
        // right child wins ties
        if (cmp_gt) begin
          pick_nxt = left_pos[COUNT_W-1:0];
          pval_nxt = lval_r;
        end else begin
          pick_nxt = right_pos[COUNT_W-1:0];
          pval_nxt = mem_rdata;
        end
        state_nxt = ST_DN_MOVE;
      end
      ST_DN_MOVE: begin
        mem_we = 1'b1;
        if (cmp_gt) begin
          mem_wdata = pval_r;            // child moves up
          pos_nxt   = pick_r;
          state_nxt = ST_DN_RDL;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign mem_waddr = pos_to_addr(wr_pos);
  // Root shadow tracks store position 1.
  assign root_nxt  = (mem_we && wr_pos == COUNT_W'(1)) ? mem_wdata : root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    pick_r <= pick_nxt;
    key_r  <= key_nxt;
    lval_r <= lval_nxt;
    pval_r <= pval_nxt;
    root_r <= root_nxt;
  end

  assign busy           = (state_r != ST_IDLE);
  assign status.done    = (state_r == ST_DONE);
  assign status.dropped = dropped_r;
  assign status.count   = count_r;
  assign status.root    = root_r;

endmodule

`default_nettype wire

FILE: rtl/binary_max_heap_queue.sv
// Binary max-heap priority queue: push / pop of signed 32-bit keys, one result per item.
// A push moves its key up at most 10 levels, a pop moves the last entry down at most 9;
// a dropped item (push on full, pop on empty) still yields a result. One item in flight;
// start transfers again in the result cycle, so a new item is taken only once the last
// is through; out_valid is high one cycle per item.
// Sync active-low reset empties the queue, store not cleared. Uses bmhq_pkg/_ram/_sift.
`default_nettype none

module binary_max_heap_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire bmhq_pkg::in_t in_data,
  output logic               out_valid,
  output bmhq_pkg::out_t     out_data
);
  import bmhq_pkg::*;

  logic         accept;
  sift_status_t status;
  logic         mem_we;
  addr_t        mem_waddr;
  key_t         mem_wdata;
  addr_t        mem_raddr;
  logic [KEY_W-1:0] mem_rdata;

  logic         out_valid_r, out_valid_nxt;
  out_t         out_data_r, out_data_nxt;

  // An input transfer happens when start meets an idle engine.
  assign accept = start && !busy;

  // Heap store: position p lives at address p-1.
  bmhq_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bmhq_sift u_sift (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_data),
    .busy      (busy),
    .status    (status),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (key_t'(mem_rdata))
  );

  // Result formatting: an empty queue reports a zero top.
  always_comb begin
    out_valid_nxt            = status.done;
    out_data_nxt.entry_count = status.count;
    out_data_nxt.is_empty    = (status.count == '0);
    out_data_nxt.top_value   = (status.count == '0) ? '0 : status.root;
    out_data_nxt.dropped     = status.dropped;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: rtl/bmhq_checker.sv
// Port-level checker for binary_max_heap_queue, bound to the top level.
// Depends on bmhq_pkg.
`default_nettype none

module bmhq_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           start,
  input wire logic           busy,
  input wire bmhq_pkg::in_t  in_data,
  input wire logic           out_valid,
  input wire bmhq_pkg::out_t out_data
);
  import bmhq_pkg::*;

  // An accepted item keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not raise busy");

  // A result is shown for a single cycle.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.is_empty == (out_data.entry_count == '0)))
    else $error("empty flag disagrees with count");

  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.is_empty) |-> (out_data.top_value == '0))
    else $error("empty queue reports nonzero top");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.entry_count <= COUNT_W'(CAPACITY)))
    else $error("count exceeds capacity");

endmodule

bind binary_max_heap_queue bmhq_checker u_bmhq_checker (.*);

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for binary_max_heap_queue: push/pop traffic with random gaps,
// checked against a behavioral max-heap kept inside the bench.
// Depends on bmhq_pkg and the binary_max_heap_queue RTL.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bmhq_pkg::*;

  // Generous: well above the slowest legal run (every pop walking all levels,
  // every transfer behind the longest random gap).
  localparam int MAX_CYCLES = 1_000_000;
  // Settle time after the last result.
  localparam int SETTLE_CYCLES = 60;
  // The final stretch of the backlog is sent back to back.
  localparam int NO_GAP_TAIL = 150;

  typedef struct {
    in_t  data;
    logic drain_first;  // hold this command until the queue is quiet
  } queued_cmd_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_t  in_data = '0;
  logic busy;
  logic out_valid;
  out_t out_data;

  queued_cmd_t cmd_backlog[$];  // commands not yet presented
  out_t        status_due[$];   // predicted status, oldest first
  int          fail_count = 0;
  int          cycle_count = 0;
  int          gap_left = 0;
  int unsigned plan_depth = 0;  // occupancy tracked while the backlog is built

  // Behavioral heap, 1-based like the block.
  key_t        shadow_heap[1:CAPACITY];
  int unsigned shadow_count = 0;

  binary_max_heap_queue DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: applies one accepted command to the shadow heap and returns the
  // status the block must report for it.
  // ---------------------------------------------------------------------------
  function automatic out_t apply_heap_op(input in_t item);
    int unsigned idx;
    int unsigned left;
    int unsigned pick;
    logic        moving;
    key_t        tmp;
    out_t        res;
    res.dropped = 1'b0;
    if (item.cmd == CMD_PUSH) begin
      if (shadow_count >= CAPACITY) begin
        res.dropped = 1'b1;           // full: key discarded
      end else begin
        shadow_count++;
        idx = shadow_count;
        shadow_heap[idx] = item.value;
        // sift up while strictly greater than the parent; ties stop
        while (idx > 1 && shadow_heap[idx] > shadow_heap[idx / 2]) begin
          tmp = shadow_heap[idx];
          shadow_heap[idx] = shadow_heap[idx / 2];
          shadow_heap[idx / 2] = tmp;
          idx = idx / 2;
        end
      end
    end else if (shadow_count == 0) begin
      res.dropped = 1'b1;             // empty: nothing to remove
    end else begin
      shadow_heap[1] = shadow_heap[shadow_count];
      shadow_count--;
      idx = 1;
      moving = 1'b1;
      // sift down; only children within the count are looked at,
      // and the right child wins a tie between the two
      while (moving && 2 * idx <= shadow_count) begin
        left = 2 * idx;
        if (left + 1 > shadow_count || shadow_heap[left] > shadow_heap[left + 1])
          pick = left;
        else
          pick = left + 1;
        if (shadow_heap[pick] > shadow_heap[idx]) begin
          tmp = shadow_heap[pick];
          shadow_heap[pick] = shadow_heap[idx];
          shadow_heap[idx] = tmp;
          idx = pick;
        end else begin
          moving = 1'b0;
        end
      end
    end
    res.top_value   = (shadow_count != 0) ? shadow_heap[1] : key_t'(0);
    res.entry_count = pos_t'(shadow_count);
    res.is_empty    = (shadow_count == 0);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Keys: mostly full-range, with a share of extremes and a narrow band
  // around zero so that ties are frequent.
  function automatic key_t pick_key();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return key_t'(32'h8000_0000);
          1:       return key_t'(32'h7FFF_FFFF);
          2:       return key_t'(0);
          default: return key_t'(-1);
        endcase
      end
      1, 2, 3: return key_t'($signed($urandom_range(0, 16)) - 8);
      default: return key_t'($urandom);
    endcase
  endfunction

  task automatic enqueue(input logic cmd, input key_t value, input logic drain_first);
    queued_cmd_t q;
    q.data.cmd   = cmd;
    q.data.value = value;
    q.drain_first = drain_first;
    cmd_backlog.push_back(q);
    if (cmd == CMD_PUSH && plan_depth < CAPACITY) plan_depth++;
    if (cmd == CMD_POP && plan_depth > 0) plan_depth--;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents one command at a time, holds it until the transfer, and
  // inserts random idle bursts between transfers.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_proc
    logic        took;
    logic        next_start;
    queued_cmd_t nxt;
    if (!rst_n) begin
      start   <= 1'b0;
      in_data <= '0;
      gap_left = 0;
    end else begin
      took = start && !busy;
      if (took) status_due.push_back(apply_heap_op(in_data));
      if (!(start && !took)) begin
        next_start = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_backlog.size() > 0) begin
          if (cmd_backlog[0].drain_first && (took || busy || status_due.size() != 0)) begin
            // hold off until every outstanding result has come back
          end else if (cmd_backlog.size() > NO_GAP_TAIL &&
                       (cmd_backlog.size() % 400) >= 100 &&
                       $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(1, 18) - 1;
          end else begin
            nxt = cmd_backlog.pop_front();
            in_data    <= nxt.data;
            next_start = 1'b1;
          end
        end
        start <= next_start;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed result is checked against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_proc
    out_t want;
    if (rst_n && out_valid) begin
      if (status_due.size() == 0) begin
        $error("unexpected result: top_value %0d entry_count %0d",
               out_data.top_value, out_data.entry_count);
        fail_count++;
      end else begin
        want = status_due.pop_front();
        if (out_data.top_value !== want.top_value) begin
          $error("top_value mismatch: expected %0d, actual %0d",
                 want.top_value, out_data.top_value);
          fail_count++;
        end
        if (out_data.entry_count !== want.entry_count) begin
          $error("entry_count mismatch: expected %0d, actual %0d",
                 want.entry_count, out_data.entry_count);
          fail_count++;
        end
        if (out_data.is_empty !== want.is_empty) begin
          $error("is_empty mismatch: expected %0b, actual %0b",
                 want.is_empty, out_data.is_empty);
          fail_count++;
        end
        if (out_data.dropped !== want.dropped) begin
          $error("dropped mismatch: expected %0b, actual %0b",
                 want.dropped, out_data.dropped);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= MAX_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: build the backlog, release reset, wait for the queue to drain.
  // ---------------------------------------------------------------------------
  initial begin
    // Directed: pop on empty, extremes, parent ties, right-child tie on pop.
    enqueue(CMD_POP,  key_t'($urandom), 1'b0);
    enqueue(CMD_PUSH, key_t'(0), 1'b0);
    enqueue(CMD_PUSH, key_t'(32'h7FFF_FFFF), 1'b0);
    enqueue(CMD_PUSH, key_t'(32'h8000_0000), 1'b0);
    enqueue(CMD_PUSH, key_t'(-1), 1'b0);
    enqueue(CMD_PUSH, key_t'(0), 1'b0);
    repeat (5) enqueue(CMD_POP, key_t'($urandom), 1'b0);
    enqueue(CMD_POP,  key_t'($urandom), 1'b0);
    repeat (4) enqueue(CMD_PUSH, key_t'(3), 1'b0);
    enqueue(CMD_POP,  key_t'($urandom), 1'b0);
    enqueue(CMD_PUSH, key_t'(9), 1'b0);
    repeat (4) enqueue(CMD_POP, key_t'($urandom), 1'b0);

    // Mixed traffic on a shallow heap; first transfer waits for a quiet queue.
    for (int i = 0; i < 100; i++)
      enqueue(($urandom_range(0, 99) < 45) ? CMD_POP : CMD_PUSH, pick_key(), i == 0);

    // Fill to capacity, mostly pushes, then hammer the full queue.
    while (plan_depth < CAPACITY)
      enqueue(($urandom_range(0, 15) == 0) ? CMD_POP : CMD_PUSH, pick_key(), 1'b0);
    for (int i = 0; i < 16; i++)
      enqueue(($urandom_range(0, 3) == 0) ? CMD_POP : CMD_PUSH, pick_key(), 1'b0);

    // Deep sift-downs off the nearly full heap.
    for (int i = 0; i < 150; i++)
      enqueue(($urandom_range(0, 15) == 0) ? CMD_PUSH : CMD_POP, pick_key(), i == 0);

    // Closing mixed traffic; the tail runs without gaps.
    for (int i = 0; i < 100; i++)
      enqueue(($urandom_range(0, 99) < 45) ? CMD_POP : CMD_PUSH, pick_key(), 1'b0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (cmd_backlog.size() != 0 || start || busy || status_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bmhq_pkg.sv
rtl/bmhq_ram.sv
rtl/bmhq_sift.sv
rtl/binary_max_heap_queue.sv
rtl/bmhq_checker.sv
tb/testbench.sv
